@@ sv/bfc_pkg.sv @@
`default_nettype none

package bfc_pkg;

  // Frame layout constants.
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [15:0] FRAME_MAGIC   = 16'h4454;
  localparam logic [7:0]  FRAME_VERSION = 8'd1;
  localparam logic [16:0] HDR_LEN       = 17'd41;
  localparam logic [16:0] CRC_LEN       = 17'd4;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Byte positions at which a header item completes, and the position from which the CRC update starts.
  localparam logic [15:0] POS_MAGIC_END   = 16'd1;
  localparam logic [15:0] POS_VERSION     = 16'd2;
  localparam logic [15:0] POS_ID_END      = 16'd10;
  localparam logic [15:0] POS_SRC_END     = 16'd14;
  localparam logic [15:0] POS_DST_END     = 16'd18;
  localparam logic [15:0] POS_CURR_END    = 16'd22;
  localparam logic [15:0] POS_CUST_END    = 16'd26;
  localparam logic [15:0] POS_SIZE_END    = 16'd28;
  localparam logic [15:0] POS_PRIO        = 16'd29;
  localparam logic [15:0] POS_CLASS       = 16'd30;
  localparam logic [15:0] POS_TGEN_END    = 16'd34;
  localparam logic [15:0] POS_TTL_END     = 16'd38;
  localparam logic [15:0] POS_PLEN_END    = 16'd40;
  localparam logic [15:0] POS_CRC_START   = 16'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    FLD_ID    = 4'd0,
    FLD_SRC   = 4'd1,
    FLD_DST   = 4'd2,
    FLD_CURR  = 4'd3,
    FLD_CUST  = 4'd4,
    FLD_SIZE  = 4'd5,
    FLD_PRIO  = 4'd6,
    FLD_CLASS = 4'd7,
    FLD_TGEN  = 4'd8,
    FLD_TTL   = 4'd9,
    FLD_PLEN  = 4'd10
  } field_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_MAGIC        = 3'd2,
    ST_VERSION      = 3'd3,
    ST_SIZE         = 3'd4,
    ST_PAYLOAD_LONG = 3'd5,
    ST_LENGTH       = 3'd6,
    ST_CRC          = 3'd7
  } status_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [3:0]  field_index;
    logic [63:0] value;
    status_e     status;
  } bfc_result_t;

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/bfc_deframe.sv @@
`default_nettype none

module bfc_deframe
  import bfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 160
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output bfc_result_t      result_o
);

  localparam logic [15:0] MaxPayload = 16'(MAX_PAYLOAD);

  logic [15:0] byte_count_q, byte_count_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] tail_q, tail_d;
  logic [63:0] accum_q, accum_d;
  logic [15:0] total_q, total_d;
  logic [15:0] plen_q, plen_d;
  logic [1:0]  flags_q, flags_d;

  logic [15:0] pos;
  logic [16:0] len;
  logic [16:0] payload_end;
  logic        field_hit;
  field_e      field_sel;
  logic [63:0] field_mask;
  status_e     verdict;

  assign pos         = byte_count_q;
  assign len         = {1'b0, pos} + 17'd1;
  assign payload_end = HDR_LEN + {1'b0, plen_q};

  always_comb begin
    crc_d        = (pos >= POS_CRC_START) ? crc_byte(crc_q, tail_q[31:24]) : crc_q;
    tail_d       = {tail_q[23:0], byte_i};
    accum_d      = {accum_q[55:0], byte_i};
    total_d      = total_q;
    plen_d       = plen_q;
    flags_d      = flags_q;
    byte_count_d = (byte_count_q != COUNT_MAX) ? byte_count_q + 16'd1 : byte_count_q;
    field_hit    = 1'b1;
    field_sel    = FLD_ID;
    field_mask   = '0;

    unique case (pos)
      POS_MAGIC_END: begin
        field_hit = 1'b0;
        if (accum_d[15:0] != FRAME_MAGIC) flags_d[0] = 1'b1;
      end
      POS_VERSION: begin
        field_hit = 1'b0;
        if (byte_i != FRAME_VERSION) flags_d[1] = 1'b1;
      end
      POS_ID_END:   begin field_sel = FLD_ID;   field_mask = '1; end
      POS_SRC_END:  begin field_sel = FLD_SRC;  field_mask = 64'hFFFF_FFFF; end
      POS_DST_END:  begin field_sel = FLD_DST;  field_mask = 64'hFFFF_FFFF; end
      POS_CURR_END: begin field_sel = FLD_CURR; field_mask = 64'hFFFF_FFFF; end
      POS_CUST_END: begin field_sel = FLD_CUST; field_mask = 64'hFFFF_FFFF; end
      POS_SIZE_END: begin
        field_sel  = FLD_SIZE;
        field_mask = 64'hFFFF;
        total_d    = accum_d[15:0];
      end
      POS_PRIO:     begin field_sel = FLD_PRIO;  field_mask = 64'hFF; end
      POS_CLASS:    begin field_sel = FLD_CLASS; field_mask = 64'hFF; end
      POS_TGEN_END: begin field_sel = FLD_TGEN;  field_mask = 64'hFFFF_FFFF; end
      POS_TTL_END:  begin field_sel = FLD_TTL;   field_mask = 64'hFFFF_FFFF; end
      POS_PLEN_END: begin
        field_sel  = FLD_PLEN;
        field_mask = 64'hFFFF;
        plen_d     = accum_d[15:0];
      end
      default: field_hit = 1'b0;
    endcase

    // Verdict priority follows the frame checks in order.
    if (len < HDR_LEN + CRC_LEN)                           verdict = ST_SHORT;
    else if (flags_d[0])                                   verdict = ST_MAGIC;
    else if (flags_d[1])                                   verdict = ST_VERSION;
    else if ({1'b0, total_d} != len)                       verdict = ST_SIZE;
    else if (plen_d > MaxPayload)                          verdict = ST_PAYLOAD_LONG;
    else if (HDR_LEN + {1'b0, plen_d} + CRC_LEN != len)    verdict = ST_LENGTH;
    else if (~crc_d != tail_d)                             verdict = ST_CRC;
    else                                                   verdict = ST_OK;

    result_o = '{valid: 1'b0, kind: KIND_PAYLOAD, field_index: 4'd0, value: 64'd0,
                 status: ST_OK};
    if (last_i) begin
      result_o.valid  = 1'b1;
      result_o.kind   = KIND_VERDICT;
      result_o.status = verdict;
    end else if (field_hit) begin
      result_o.valid       = 1'b1;
      result_o.kind        = KIND_FIELD;
      result_o.field_index = field_sel;
      result_o.value       = accum_d & field_mask;
    end else if ({1'b0, pos} >= HDR_LEN && {1'b0, pos} < payload_end) begin
      result_o.valid = 1'b1;
      result_o.value = {56'd0, byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= '1;
      tail_q       <= '0;
      accum_q      <= '0;
      total_q      <= '0;
      plen_q       <= '0;
      flags_q      <= '0;
    end else if (step_i) begin
      if (last_i) begin
        byte_count_q <= '0;
        crc_q        <= '1;
        tail_q       <= '0;
        accum_q      <= '0;
        total_q      <= '0;
        plen_q       <= '0;
        flags_q      <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        crc_q        <= crc_d;
        tail_q       <= tail_d;
        accum_q      <= accum_d;
        total_q      <= total_d;
        plen_q       <= plen_d;
        flags_q      <= flags_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/bundle_frame_checker_crc32.sv @@
// Bundle frame checker: takes a received frame one byte per transaction on the
// slave stream (tlast on the final byte) and produces at most one result per
// byte on the master stream. Each big-endian header field (id, src, dst, curr,
// cust, size, prio, class, t_gen, ttl, payload length) is reported as soon as its
// last byte arrives, payload bytes are forwarded as they arrive, and the final
// byte yields only a verdict: short, bad magic, bad version, size mismatch,
// payload too long, length mismatch or CRC-32 mismatch, checked in that order.
// The CRC-32 (reflected, polynomial 0xEDB88320) covers every byte but the last
// four, which carry the expected value. One byte is taken every clock cycle
// while the master stream does not stall; the whole byte step, including the eight-bit
// CRC update, is combinational from the input register to the result register,
// the two registers an accepted byte passes through. The byte counter saturates
// at 65535. MAX_PAYLOAD sets the largest payload length that passes.
`default_nettype none

module bundle_frame_checker_crc32
  import bfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 160
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_frame
  // Master stream.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [71:0] m_axis_tdata,   // [3:0] field_index, [67:4] value,
                                           // [70:68] status, [71] zero
  output      logic [1:0]  m_axis_tuser    // [1:0] kind
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic        out_valid_q;
  bfc_result_t out_q;

  bfc_result_t result;
  logic        advance;
  logic        step;

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  bfc_deframe #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  // A byte that produces no result simply leaves the result register empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.status, out_q.value, out_q.field_index};
  assign m_axis_tuser  = out_q.kind;

endmodule

`default_nettype wire
